[sv/circular_box_blur_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef CIRCULAR_BOX_BLUR_TOP_ASSERT_SVH
`define CIRCULAR_BOX_BLUR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CBB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cbb_pkg.sv]
package cbb_pkg;

  localparam int MaxBins = 64;
  localparam int BinAw   = $clog2(MaxBins);

  localparam int MagW   = 24;
  localparam int IdxW   = 6;
  localparam int RadW   = 6;
  localparam int RecipW = 17;
  localparam int LenW   = 7;
  localparam int SumW   = 31;
  localparam int ProdW  = SumW + RecipW;
  localparam int SeedW  = RadW + 1;
  localparam int CfgIdxW = 2;

  localparam logic [RadW-1:0]   RadiusReset = '0;
  localparam logic [RecipW-1:0] RecipReset  = RecipW'(65536);
  localparam logic [LenW-1:0]   LenReset    = LenW'(64);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_RECIP  = 2'd1,
    CFG_LEN    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MOD,
    ST_SEED,
    ST_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    ISS_SEED,
    ISS_FIRST,
    ISS_STEP
  } issue_kind_e;

  // One slot issued into the datapath together with its memory reads.
  typedef struct packed {
    logic              valid;
    issue_kind_e       kind;
    logic              clr;
    logic [IdxW-1:0]   idx;
    logic              last;
  } issue_t;

endpackage

[sv/circular_box_blur_top.sv]
// Circular box blur over one frame of magnitude bins.
// Input channel (in_valid_i / in_stall_o / mag_i): one bin per item, stored in
// bin order. The channel accepts one bin per cycle while loading a frame.
// When frame_len bins are in, the input stalls and the block emits frame_len
// results on the output channel (out_valid_o / out_stall_i / blurred_o,
// bin_index_o, frame_last_o), bin 0 first; frame_last_o marks the last one.
// Result k is the sum of bins k-r..k+r, wrapped modulo frame_len, scaled by
// kernel_recip (Q1.16, rounded) and saturated to 24 bits; radius 0 passes bins.
// After the frame's last bin the block reduces the radius modulo frame_len,
// then sums the first window of 2r+1 bins (one bin per cycle from memory port
// A while the output does not stall), then streams results at one per cycle
// unless stalled; ports A and B of the bin memory read the entering and leaving bins.
// A stalled result holds and freezes the whole emit pipeline.
// Reset returns to loading bin 0 with radius 0, weight one and 64 bins.
// Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) is always ready;
// the user must write it only while the block is idle; the block does not enforce it.
module circular_box_blur_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cbb_pkg::MagW-1:0]      mag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cbb_pkg::MagW-1:0]      blurred_o,
  output logic [cbb_pkg::IdxW-1:0]      bin_index_o,
  output logic                          frame_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cbb_pkg::RecipW-1:0]    cfg_data_i
);
  import cbb_pkg::*;

  logic [RadW-1:0]   radius_q;
  logic [RecipW-1:0] recip_q;
  logic [LenW-1:0]   len_q;

  logic              en;
  logic              we;
  logic [BinAw-1:0]  waddr;
  logic [BinAw-1:0]  raddr_a;
  logic [BinAw-1:0]  raddr_b;
  logic [MagW-1:0]   rdata_a;
  logic [MagW-1:0]   rdata_b;
  issue_t            issue;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      recip_q  <= RecipReset;
      len_q    <= LenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS: radius_q <= cfg_data_i[RadW-1:0];
        CFG_RECIP:  recip_q  <= cfg_data_i;
        CFG_LEN:    len_q    <= cfg_data_i[LenW-1:0];
        default:    ;
      endcase
    end
  end

  cbb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .en_i        (en),
    .radius_i    (radius_q),
    .frame_len_i (len_q),
    .we_o        (we),
    .waddr_o     (waddr),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .issue_o     (issue)
  );

  cbb_ram #(
    .Depth (MaxBins),
    .Width (MagW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (mag_i),
    .re_i      (en),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  cbb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b),
    .recip_i      (recip_q),
    .pass_i       (radius_q == '0),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .blurred_o    (blurred_o),
    .bin_index_o  (bin_index_o),
    .frame_last_o (frame_last_o)
  );

endmodule

[sv/cbb_ram.sv]
module cbb_ram #(
  parameter int Depth = 64,
  parameter int Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[sv/cbb_seq.sv]
module cbb_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        en_i,
  input  logic [cbb_pkg::RadW-1:0]    radius_i,
  input  logic [cbb_pkg::LenW-1:0]    frame_len_i,
  output logic                        we_o,
  output logic [cbb_pkg::BinAw-1:0]   waddr_o,
  output logic [cbb_pkg::BinAw-1:0]   raddr_a_o,
  output logic [cbb_pkg::BinAw-1:0]   raddr_b_o,
  output cbb_pkg::issue_t             issue_o
);
  import cbb_pkg::*;

  seq_state_e        state_q, state_d;
  logic [BinAw-1:0]  cnt_q, cnt_d;
  logic [RadW-1:0]   rm_q, rm_d;
  logic [BinAw-1:0]  pa_q, pa_d;
  logic [BinAw-1:0]  pd_q, pd_d;
  logic [SeedW-1:0]  d_q, d_d;
  logic [BinAw-1:0]  k_q, k_d;

  logic [LenW-1:0]   n;
  logic [LenW-1:0]   cnt_inc;
  logic [BinAw-1:0]  seed_start;
  logic              k_last;

  function automatic logic [BinAw-1:0] wrap_inc(logic [BinAw-1:0] p, logic [LenW-1:0] len);
    logic [LenW-1:0] nxt;
    nxt = LenW'(p) + LenW'(1);
    return (nxt >= len) ? '0 : BinAw'(nxt);
  endfunction

  always_comb begin
    if (frame_len_i == '0) begin
      n = LenW'(1);
    end else if (frame_len_i > LenW'(MaxBins)) begin
      n = LenW'(MaxBins);
    end else begin
      n = frame_len_i;
    end
  end

  assign cnt_inc    = LenW'(cnt_q) + LenW'(1);
  // (-r) mod n, with rm already reduced below n
  assign seed_start = (rm_q == '0) ? '0 : BinAw'(n - LenW'(rm_q));
  assign k_last     = (LenW'(k_q) == (n - LenW'(1)));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rm_d    = rm_q;
    pa_d    = pa_q;
    pd_d    = pd_q;
    d_d     = d_q;
    k_d     = k_q;
    we_o    = 1'b0;
    issue_o = '{valid: 1'b0, kind: ISS_SEED, clr: 1'b0, idx: '0, last: 1'b0};
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          we_o = 1'b1;
          if (cnt_inc >= n) begin
            cnt_d   = '0;
            rm_d    = radius_i;
            state_d = ST_MOD;
          end else begin
            cnt_d = BinAw'(cnt_inc);
          end
        end
      end
      ST_MOD: begin
        // radius mod frame length by repeated subtraction
        if (LenW'(rm_q) >= n) begin
          rm_d = RadW'(LenW'(rm_q) - n);
        end else begin
          pa_d    = seed_start;
          pd_d    = seed_start;
          d_d     = '0;
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        if (en_i) begin
          issue_o.valid = 1'b1;
          issue_o.kind  = ISS_SEED;
          issue_o.clr   = (d_q == '0);
          pa_d          = wrap_inc(pa_q, n);
          d_d           = d_q + SeedW'(1);
          if (d_q == {radius_i, 1'b0}) begin
            k_d     = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (en_i) begin
          issue_o.valid = 1'b1;
          issue_o.idx   = IdxW'(k_q);
          issue_o.last  = k_last;
          if (k_q == '0) begin
            issue_o.kind = ISS_FIRST;
          end else begin
            issue_o.kind = ISS_STEP;
            pa_d         = wrap_inc(pa_q, n);
            pd_d         = wrap_inc(pd_q, n);
          end
          k_d = k_q + BinAw'(1);
          if (k_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      rm_q    <= '0;
      pa_q    <= '0;
      pd_q    <= '0;
      d_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rm_q    <= rm_d;
      pa_q    <= pa_d;
      pd_q    <= pd_d;
      d_q     <= d_d;
      k_q     <= k_d;
    end
  end

  assign in_stall_o = (state_q != ST_LOAD);
  assign waddr_o    = cnt_q;
  assign raddr_a_o  = pa_q;
  assign raddr_b_o  = pd_q;

endmodule

[sv/cbb_dp.sv]
module cbb_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cbb_pkg::issue_t            issue_i,
  input  logic [cbb_pkg::MagW-1:0]   rdata_a_i,
  input  logic [cbb_pkg::MagW-1:0]   rdata_b_i,
  input  logic [cbb_pkg::RecipW-1:0] recip_i,
  input  logic                       pass_i,
  output logic                       en_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cbb_pkg::MagW-1:0]   blurred_o,
  output logic [cbb_pkg::IdxW-1:0]   bin_index_o,
  output logic                       frame_last_o
);
  import cbb_pkg::*;

  localparam int RndW = ProdW + 1;
  localparam logic [RndW-1:0] RoundHalf = RndW'(32768);
  localparam logic [MagW-1:0] MagMax    = '1;

  logic              en;

  // stage 1: read data returns
  logic              v1_q;
  issue_kind_e       kind1_q;
  logic              clr1_q;
  logic [IdxW-1:0]   idx1_q;
  logic              last1_q;
  logic [SumW-1:0]   s_new;

  // stage 2: running window sum
  logic              v2_q;
  logic [IdxW-1:0]   idx2_q;
  logic              last2_q;
  logic [SumW-1:0]   s_q;

  // stage 3: scaled product
  logic              v3_q;
  logic [IdxW-1:0]   idx3_q;
  logic              last3_q;
  logic [ProdW-1:0]  prod_q;
  logic [MagW-1:0]   pass_q;
  logic [RndW-1:0]   rnd;
  logic              sat;
  logic [MagW-1:0]   val3;

  // output register
  logic              out_valid_q;
  logic [MagW-1:0]   blurred_q;
  logic [IdxW-1:0]   idx_q;
  logic              last_q;

  // whole pipeline holds while the result register is stalled
  assign en   = !(out_valid_q && out_stall_i);
  assign en_o = en;

  always_comb begin
    unique case (kind1_q)
      ISS_SEED:  s_new = (clr1_q ? '0 : s_q) + SumW'(rdata_a_i);
      ISS_STEP:  s_new = s_q + SumW'(rdata_a_i) - SumW'(rdata_b_i);
      default:   s_new = s_q;
    endcase
  end

  assign rnd  = RndW'(prod_q) + RoundHalf;
  assign sat  = (rnd[RndW-1:16] > RndW'(MagMax));
  assign val3 = pass_i ? pass_q : (sat ? MagMax : rnd[16 +: MagW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      s_q         <= '0;
    end else if (en) begin
      v1_q        <= issue_i.valid;
      v2_q        <= v1_q && (kind1_q != ISS_SEED);
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
      if (v1_q) begin
        s_q <= s_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q   <= issue_i.kind;
      clr1_q    <= issue_i.clr;
      idx1_q    <= issue_i.idx;
      last1_q   <= issue_i.last;
      idx2_q    <= idx1_q;
      last2_q   <= last1_q;
      prod_q    <= ProdW'(s_q) * ProdW'(recip_i);
      pass_q    <= s_q[MagW-1:0];
      idx3_q    <= idx2_q;
      last3_q   <= last2_q;
      blurred_q <= val3;
      idx_q     <= idx3_q;
      last_q    <= last3_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign blurred_o    = blurred_q;
  assign bin_index_o  = idx_q;
  assign frame_last_o = last_q;

endmodule

[sv/cbb_checker.sv]
`include "circular_box_blur_top_assert.svh"

module cbb_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic [cbb_pkg::MagW-1:0]    blurred_o,
  input  logic [cbb_pkg::IdxW-1:0]    bin_index_o,
  input  logic                        frame_last_o
);
  import cbb_pkg::*;

  logic [IdxW-1:0] exp_idx_q;
  logic            out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_acc) begin
      exp_idx_q <= frame_last_o ? '0 : exp_idx_q + IdxW'(1);
    end
  end

  `CBB_ASSERT_SAME(a_idx_order, out_valid_o, bin_index_o == exp_idx_q, "result bin index out of order")
  `CBB_ASSERT_NEXT(a_no_gap, out_valid_o && !frame_last_o, out_valid_o, "gap inside a frame of results")
  `CBB_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(blurred_o) && $stable(bin_index_o) && $stable(frame_last_o), "stalled result changed")

endmodule

bind circular_box_blur_top cbb_checker u_checker (.*);
